>>> rtl/tick_timebase_with_countdown_unit_macros.svh
// assertion macros shared by the timebase checker
`ifndef TICK_TIMEBASE_WITH_COUNTDOWN_UNIT_MACROS_SVH
`define TICK_TIMEBASE_WITH_COUNTDOWN_UNIT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define TBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tbc_pkg.sv
// shared types and constants for the tick timebase with countdown
`default_nettype none

package tbc_pkg;

    localparam int OPCODE_W = 2;
    localparam int SEC_W    = 32;
    localparam int US_W     = 20;
    localparam int CD_W     = 32;
    localparam int SUB_W    = 16;
    localparam int FINE_W   = 22;
    localparam int SUBUS_W  = 21;

    localparam int TICK_US            = 31250;
    localparam int US_PER_SEC         = 1000000;
    localparam int SUB_TICK_SHIFT     = 10;
    localparam int SLEEP_TICK_SECONDS = 2;
    localparam int MAX_ALIGNED_US     = 968750;
    localparam int TICKS_PER_SEC      = US_PER_SEC / TICK_US;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK           = 2'd0,
        OP_SET_TIME       = 2'd1,
        OP_LOAD_COUNTDOWN = 2'd2,
        OP_SAMPLE         = 2'd3
    } t_opcode;

    // item held between the input register and the update stage
    typedef struct packed {
        logic                valid;
        t_opcode             opcode;
        logic [SEC_W-1:0]    new_seconds;
        logic [US_W-1:0]     aligned_us;
        logic [CD_W-1:0]     new_countdown;
        logic [SUBUS_W-1:0]  sub_us;
    } t_stage;

endpackage

`default_nettype wire

>>> rtl/tbc_ifs.sv
// valid/ready channel interfaces for input items and results
`default_nettype none

interface tbc_in_if;
    import tbc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [SEC_W-1:0]    new_seconds;
    logic [US_W-1:0]     new_microseconds;
    logic [CD_W-1:0]     new_countdown;
    logic [SUB_W-1:0]    sub_tick_count;

    modport source (
        output valid, opcode, new_seconds, new_microseconds, new_countdown, sub_tick_count,
        input  ready
    );
    modport sink (
        input  valid, opcode, new_seconds, new_microseconds, new_countdown, sub_tick_count,
        output ready
    );
endinterface

interface tbc_out_if;
    import tbc_pkg::*;

    logic               valid;
    logic               ready;
    logic [SEC_W-1:0]   seconds;
    logic [US_W-1:0]    microseconds;
    logic [FINE_W-1:0]  fine_microseconds;
    logic [CD_W-1:0]    countdown;
    logic               countdown_done;

    modport source (
        output valid, seconds, microseconds, fine_microseconds, countdown, countdown_done,
        input  ready
    );
    modport sink (
        input  valid, seconds, microseconds, fine_microseconds, countdown, countdown_done,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/tick_timebase_with_countdown_unit.sv
// top level of the tick timebase with countdown
// a result passes through the input register and then the result register
// throughput: one transaction per cycle; the input register and the result register both
// advance whenever the result register is empty or being taken
// reset: synchronous active-low i_rst_n clears time, countdown, sleep mode and both valids
`default_nettype none

module tick_timebase_with_countdown_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata,
    tbc_in_if.sink    i_in,
    tbc_out_if.source o_out
);
    import tbc_pkg::*;

    t_stage stage;
    logic   take;

    tbc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_stage (stage)
    );

    tbc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stage     (stage),
        .o_take      (take),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

>>> rtl/tbc_front.sv
// input register: aligns set-time microseconds and scales the sub-tick count
`default_nettype none

module tbc_front (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    tbc_in_if.sink         i_in,
    input  wire logic      i_take,
    output tbc_pkg::t_stage o_stage
);
    import tbc_pkg::*;

    logic                      r_valid;
    t_stage                    r_item;
    logic [TICKS_PER_SEC-2:0]  cmp;
    logic [4:0]                quot;
    logic [US_W-1:0]           n_aligned;
    logic [SEC_W-2:0]          prod;
    logic                      accept;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    // quotient by 31250 as a count of thresholds passed
    always_comb begin
        for (int k = 1; k < TICKS_PER_SEC; k++) begin
            cmp[k-1] = (i_in.new_microseconds >= US_W'(k * TICK_US));
        end
        quot = 5'($countones(cmp));
        if (i_in.new_microseconds >= US_W'(US_PER_SEC)) begin
            n_aligned = US_W'(MAX_ALIGNED_US);
        end else begin
            n_aligned = US_W'(32'(quot) * TICK_US);
        end
    end

    assign prod = (SEC_W-1)'(i_in.sub_tick_count) * (SEC_W-1)'(TICK_US);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.valid         <= 1'b1;
            r_item.opcode        <= t_opcode'(i_in.opcode);
            r_item.new_seconds   <= i_in.new_seconds;
            r_item.aligned_us    <= n_aligned;
            r_item.new_countdown <= i_in.new_countdown;
            r_item.sub_us        <= prod[SEC_W-2:SUB_TICK_SHIFT];
        end
    end

    always_comb begin
        o_stage       = r_item;
        o_stage.valid = r_valid;
    end

endmodule

`default_nettype wire

>>> rtl/tbc_core.sv
// time and countdown state, mode register and result register
`default_nettype none

module tbc_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata,
    input  wire tbc_pkg::t_stage i_stage,
    output logic            o_take,
    tbc_out_if.source       o_out
);
    import tbc_pkg::*;

    logic               r_sleep_mode;
    logic [SEC_W-1:0]   r_seconds;
    logic [US_W-1:0]    r_us;
    logic [CD_W-1:0]    r_countdown;
    logic               r_out_valid;
    logic [SEC_W-1:0]   r_out_seconds;
    logic [US_W-1:0]    r_out_us;
    logic [FINE_W-1:0]  r_out_fine;
    logic [CD_W-1:0]    r_out_countdown;
    logic               r_out_done;

    logic [SEC_W-1:0]   n_seconds;
    logic [US_W-1:0]    n_us;
    logic [CD_W-1:0]    n_countdown;
    logic               n_done;
    logic [US_W:0]      us_sum;
    logic               fire;

    assign o_take = !r_out_valid || o_out.ready;
    assign fire   = i_stage.valid && o_take;

    always_comb begin
        n_seconds   = r_seconds;
        n_us        = r_us;
        n_countdown = r_countdown;
        n_done      = 1'b0;
        us_sum      = (US_W+1)'(r_us) + (US_W+1)'(TICK_US);
        case (i_stage.opcode)
            OP_TICK: begin
                if (!r_sleep_mode) begin
                    if (us_sum >= (US_W+1)'(US_PER_SEC)) begin
                        n_us      = US_W'(us_sum - (US_W+1)'(US_PER_SEC));
                        n_seconds = r_seconds + SEC_W'(1);
                    end else begin
                        n_us = us_sum[US_W-1:0];
                    end
                    if (r_countdown != '0) begin
                        n_countdown = r_countdown - CD_W'(1);
                        n_done      = (r_countdown == CD_W'(1));
                    end
                end else begin
                    n_seconds = r_seconds + SEC_W'(SLEEP_TICK_SECONDS);
                end
            end
            OP_SET_TIME: begin
                n_seconds = i_stage.new_seconds;
                n_us      = i_stage.aligned_us;
            end
            OP_LOAD_COUNTDOWN: begin
                n_countdown = i_stage.new_countdown;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sleep_mode <= 1'b0;
            r_seconds    <= '0;
            r_us         <= '0;
            r_countdown  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sleep_mode <= i_cfg_wdata;
            end
            if (fire) begin
                r_seconds   <= n_seconds;
                r_us        <= n_us;
                r_countdown <= n_countdown;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_seconds   <= n_seconds;
            r_out_us        <= n_us;
            r_out_fine      <= FINE_W'(n_us) + FINE_W'(i_stage.sub_us);
            r_out_countdown <= n_countdown;
            r_out_done      <= n_done;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.seconds           = r_out_seconds;
    assign o_out.microseconds      = r_out_us;
    assign o_out.fine_microseconds = r_out_fine;
    assign o_out.countdown         = r_out_countdown;
    assign o_out.countdown_done    = r_out_done;

endmodule

`default_nettype wire

>>> rtl/tbc_checker.sv
// port-level checks on the result channel of the timebase
`default_nettype none

`include "tick_timebase_with_countdown_unit_macros.svh"

module tbc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_seconds,
    input wire logic [19:0] i_microseconds,
    input wire logic [21:0] i_fine_microseconds,
    input wire logic [31:0] i_countdown,
    input wire logic        i_countdown_done
);

    `TBC_ASSERT_NEXT(a_valid_holds, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `TBC_ASSERT_NEXT(a_payload_holds, i_out_valid && !i_out_ready, $stable(i_seconds) && $stable(i_microseconds) && $stable(i_countdown), "result changed while stalled")
    `TBC_ASSERT_NOW(a_us_range, i_out_valid, i_microseconds < 20'd1000000, "microseconds not normalized")
    `TBC_ASSERT_NOW(a_done_zero, i_out_valid && i_countdown_done, i_countdown == '0, "done flagged with countdown left")
    `TBC_ASSERT_NOW(a_fine_ge, i_out_valid, i_fine_microseconds >= {2'b00, i_microseconds}, "fine time below coarse time")

endmodule

bind tick_timebase_with_countdown_unit tbc_checker u_tbc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_seconds           (o_out.seconds),
    .i_microseconds      (o_out.microseconds),
    .i_fine_microseconds (o_out.fine_microseconds),
    .i_countdown         (o_out.countdown),
    .i_countdown_done    (o_out.countdown_done)
);

`default_nettype wire

>>> test/tb_tick_timebase_with_countdown_unit.sv
// self-checking testbench for the tick timebase with countdown unit
module tb_tick_timebase_with_countdown_unit;
    import tbc_pkg::*;

    typedef struct {
        logic [SEC_W-1:0]  sec;
        logic [US_W-1:0]   us;
        logic [FINE_W-1:0] fine;
        logic [CD_W-1:0]   cd;
        logic              done;
    } t_reading;

    // mirrors the time of day and countdown, holds the readings still to come out
    class timebase_checker;
        logic [SEC_W-1:0] secs;
        logic [US_W-1:0]  usecs;
        logic [CD_W-1:0]  ticks_left;
        bit               sleep;
        t_reading         pending[$];
        int               errors;

        function new();
            secs       = '0;
            usecs      = '0;
            ticks_left = '0;
            sleep      = 1'b0;
            errors     = 0;
        endfunction

        function void set_mode(bit m);
            sleep = m;
        endfunction

        function void note_item(t_opcode op, logic [SEC_W-1:0] ns, logic [US_W-1:0] nus,
                                logic [CD_W-1:0] ncd, logic [SUB_W-1:0] sub);
            t_reading    r;
            logic [20:0] us_sum;
            logic [47:0] wide_sub;
            r.done = 1'b0;
            case (op)
                OP_TICK: begin
                    if (!sleep) begin
                        us_sum = usecs + TICK_US;
                        if (us_sum >= US_PER_SEC) begin
                            us_sum = us_sum - US_PER_SEC;
                            secs   = secs + 1;
                        end
                        usecs = us_sum[US_W-1:0];
                        if (ticks_left != 0) begin
                            ticks_left = ticks_left - 1;
                            r.done     = (ticks_left == 0);
                        end
                    end else begin
                        secs = secs + SLEEP_TICK_SECONDS;
                    end
                end
                OP_SET_TIME: begin
                    secs = ns;
                    // out of range saturates to the last aligned step
                    if (nus >= US_PER_SEC)
                        usecs = MAX_ALIGNED_US;
                    else
                        usecs = (nus / TICK_US) * TICK_US;
                end
                OP_LOAD_COUNTDOWN: ticks_left = ncd;
                default: ;
            endcase
            wide_sub = sub;
            wide_sub = (wide_sub * TICK_US) >> SUB_TICK_SHIFT;
            r.fine   = usecs + wide_sub;
            r.sec    = secs;
            r.us     = usecs;
            r.cd     = ticks_left;
            pending.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= 50)
                $display("ERROR: %s got 0x%0h expected 0x%0h", what, got, want);
        endtask

        task check_result(logic [SEC_W-1:0] sec, logic [US_W-1:0] us,
                          logic [FINE_W-1:0] fine, logic [CD_W-1:0] cd, logic done);
            t_reading r;
            if (pending.size() == 0) begin
                report_mismatch("unexpected transaction, seconds", sec, 0);
                return;
            end
            r = pending.pop_front();
            if (sec !== r.sec)   report_mismatch("seconds", sec, r.sec);
            if (us !== r.us)     report_mismatch("microseconds", us, r.us);
            if (fine !== r.fine) report_mismatch("fine_microseconds", fine, r.fine);
            if (cd !== r.cd)     report_mismatch("countdown", cd, r.cd);
            if (done !== r.done) report_mismatch("countdown_done", done, r.done);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_wdata;
    bit   no_idle;
    bit   hold;
    int   n_in;

    tbc_in_if  in_ch ();
    tbc_out_if out_ch ();

    timebase_checker sb;

    tick_timebase_with_countdown_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // offers one item and returns at the edge where it is taken, valid still high
    task automatic send_item(t_opcode op, logic [SEC_W-1:0] ns, logic [US_W-1:0] nus,
                             logic [CD_W-1:0] ncd, logic [SUB_W-1:0] sub);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.opcode           <= op;
        in_ch.new_seconds      <= ns;
        in_ch.new_microseconds <= nus;
        in_ch.new_countdown    <= ncd;
        in_ch.sub_tick_count   <= sub;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_item(op, ns, nus, ncd, sub);
        n_in <= n_in + 1;
    endtask

    task automatic send_random_item();
        int                pick;
        t_opcode           op;
        logic [SEC_W-1:0]  ns;
        logic [US_W-1:0]   nus;
        logic [CD_W-1:0]   ncd;
        logic [SUB_W-1:0]  sub;
        pick = $urandom_range(0, 99);
        if (pick < 50)      op = OP_TICK;
        else if (pick < 65) op = OP_SET_TIME;
        else if (pick < 80) op = OP_LOAD_COUNTDOWN;
        else                op = OP_SAMPLE;
        ns = $urandom();
        if ($urandom_range(0, 3) == 0)
            ns = 32'hFFFF_FFFF - $urandom_range(0, 40);
        case ($urandom_range(0, 3))
            0: nus = $urandom_range(0, 999999);
            1: nus = $urandom_range(0, 31) * TICK_US;
            2: nus = $urandom();
            default: nus = $urandom_range(1000000, 1048575);
        endcase
        // small loads so that ticks run the countdown out often
        case ($urandom_range(0, 3))
            0, 1: ncd = $urandom_range(0, 20);
            2: ncd = $urandom();
            default: ncd = 32'hFFFF_FFFF - $urandom_range(0, 20);
        endcase
        if ($urandom_range(0, 3) == 0)
            sub = $urandom_range(0, 1023);
        else
            sub = $urandom();
        send_item(op, ns, nus, ncd, sub);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(bit m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_mode(m);
    endtask

    initial begin
        int ph;
        sb = new();
        n_in                   <= 0;
        no_idle                <= 1'b0;
        in_ch.valid            <= 1'b0;
        in_ch.opcode           <= '0;
        in_ch.new_seconds      <= '0;
        in_ch.new_microseconds <= '0;
        in_ch.new_countdown    <= '0;
        in_ch.sub_tick_count   <= '0;
        cfg_we                 <= 1'b0;
        cfg_wdata              <= 1'b0;
        i_rst_n                <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wake mode edges
        send_item(OP_SAMPLE, 32'hFFFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF, 16'd0);
        send_item(OP_SAMPLE, 32'd0, 20'd0, 32'd0, 16'hFFFF);
        send_item(OP_SET_TIME, 32'hFFFF_FFFF, 20'd999999, 32'd7, 16'hFFFF);
        send_item(OP_TICK, 32'd0, 20'd0, 32'd0, 16'd0);        // seconds wrap
        send_item(OP_SET_TIME, 32'd12345, 20'hFFFFF, 32'd0, 16'd1);
        send_item(OP_SET_TIME, 32'd1, 20'd1000000, 32'd0, 16'd512);
        send_item(OP_SET_TIME, 32'd2, 20'd31249, 32'd0, 16'd1023);
        send_item(OP_SET_TIME, 32'd3, 20'd31250, 32'd0, 16'd1024);
        send_item(OP_LOAD_COUNTDOWN, 32'd0, 20'd0, 32'd1, 16'd0);
        send_item(OP_TICK, 32'd0, 20'd0, 32'd0, 16'd100);     // reaches zero
        send_item(OP_TICK, 32'd0, 20'd0, 32'd0, 16'd0);       // stays at zero
        send_item(OP_LOAD_COUNTDOWN, 32'd0, 20'd0, 32'hFFFF_FFFF, 16'd0);
        send_item(OP_TICK, 32'd0, 20'd0, 32'd0, 16'hFFFF);
        send_item(OP_LOAD_COUNTDOWN, 32'd0, 20'd0, 32'd2, 16'd0);
        send_item(OP_TICK, 32'd0, 20'd0, 32'd0, 16'd0);
        send_item(OP_TICK, 32'd0, 20'd0, 32'd0, 16'd0);
        send_item(OP_LOAD_COUNTDOWN, 32'd0, 20'd0, 32'd0, 16'd0);

        // sleep mode edges
        wait_idle();
        write_mode(1'b1);
        send_item(OP_SET_TIME, 32'hFFFF_FFFE, 20'd500000, 32'd0, 16'd0);
        send_item(OP_TICK, 32'd0, 20'd0, 32'd0, 16'd0);
        send_item(OP_LOAD_COUNTDOWN, 32'd0, 20'd0, 32'd1, 16'd0);
        send_item(OP_TICK, 32'd0, 20'd0, 32'd0, 16'd777);     // countdown untouched
        send_item(OP_SAMPLE, 32'd0, 20'd0, 32'd0, 16'd12345);
        wait_idle();
        write_mode(1'b0);
        send_item(OP_TICK, 32'd0, 20'd0, 32'd0, 16'd0);

        for (ph = 0; ph < 6; ph++) begin
            wait_idle();
            if (ph == 0)      write_mode(1'b0);
            else if (ph == 1) write_mode(1'b1);
            else              write_mode($urandom_range(0, 1));
            no_idle <= (ph == 2);
            repeat (190) send_random_item();
        end

        wait_idle();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side
    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 4);
            repeat (gap) begin
                out_ch.ready <= 1'b0;
                @(posedge i_clk);
            end
            while (hold) begin
                out_ch.ready <= 1'b0;
                @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            sb.check_result(out_ch.seconds, out_ch.microseconds, out_ch.fine_microseconds,
                            out_ch.countdown, out_ch.countdown_done);
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        hold <= 1'b0;
        @(posedge i_clk);
        while (n_in < 500) @(posedge i_clk);
        hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold <= 1'b0;
    end

    initial begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
